### hw/rtl/dssa_pkg.sv
// Shared constants and types for the dual stack shared array unit.
`default_nettype none

package dssa_pkg;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned WORD_BITS = 32;

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned VALUE_BITS  = 32;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_LO = 3'd0,
    CMD_PUSH_HI = 3'd1,
    CMD_POP_LO  = 3'd2,
    CMD_POP_HI  = 3'd3,
    CMD_PEEK_LO = 3'd4,
    CMD_PEEK_HI = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK       = 2'd0,
    STAT_OVERFLOW = 2'd1,
    STAT_EMPTY    = 2'd2
  } status_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_READ = 1'b1
  } fsm_e;

endpackage

`default_nettype wire

### hw/rtl/dssa_if.sv
// Request and response channel interfaces of the dual stack shared array unit.
`default_nettype none

interface dssa_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [dssa_pkg::CMD_BITS-1:0]    command;
  logic signed [dssa_pkg::VALUE_BITS-1:0]  push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface dssa_rsp_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [dssa_pkg::VALUE_BITS-1:0]  read_value;
  logic        [dssa_pkg::STATUS_BITS-1:0] status;

  modport source (output valid, output read_value, output status, input ready);
  modport sink   (input valid, input read_value, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/dual_stack_shared_array_unit.sv
// Top level of the dual stack shared array unit: two stacks in one word memory.
//
//   Channel  Dir  Payload                          Handshake
//   req_i    in   command[2:0], push_value[31:0]   valid / ready
//   rsp_o    out  read_value[31:0], status[1:0]    valid / ready
//
// For a push, a failed command or an unused command code, the response is
// loaded into the output register at the accepting edge. A successful pop
// or peek first registers the memory word, then loads it in the read state.
// Reset (rst_ni, asynchronous, active low) clears the counts and control state.
// A stalled response holds in the output register; in the idle state a request
// is accepted while that register is empty or is being emptied that cycle.
`default_nettype none

module dual_stack_shared_array_unit #(
  parameter int unsigned DEPTH     = dssa_pkg::DEPTH,
  parameter int unsigned WORD_BITS = dssa_pkg::WORD_BITS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dssa_req_if.sink   req_i,
  dssa_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned VAL_W  = dssa_pkg::VALUE_BITS;

  // Stack one occupies entries from the bottom; stack two from the top.
  logic [CNT_W-1:0] low_q, low_d;
  logic [CNT_W-1:0] high_q, high_d;

  dssa_pkg::fsm_e state_q, state_d;

  // Output register.
  logic                                   out_valid_q, out_valid_d;
  logic signed [VAL_W-1:0]                out_value_q, out_value_d;
  logic        [dssa_pkg::STATUS_BITS-1:0] out_status_q, out_status_d;

  // Word memory with a registered read port.
  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [ADDR_W-1:0]    mem_raddr;

  logic               in_ready;
  logic               accept;
  logic [CNT_W:0]     fill_sum;
  logic               full;
  logic               low_empty;
  logic               high_empty;
  logic [2*VAL_W-1:0] push_ext;
  logic [CNT_W-1:0]   lo_push_idx;
  logic [CNT_W-1:0]   lo_top_idx;
  logic [CNT_W-1:0]   hi_push_idx;
  logic [CNT_W-1:0]   hi_top_idx;

  assign fill_sum   = {1'b0, low_q} + {1'b0, high_q};
  assign full       = (fill_sum >= (CNT_W + 1)'(DEPTH));
  assign low_empty  = (low_q == '0);
  assign high_empty = (high_q == '0);

  // Entry addresses for each stack: next free slot and current top.
  assign lo_push_idx = low_q;
  assign lo_top_idx  = low_q - CNT_W'(1);
  assign hi_push_idx = CNT_W'(DEPTH - 1) - high_q;
  assign hi_top_idx  = CNT_W'(DEPTH) - high_q;

  // The pushed word keeps the low WORD_BITS bits of the zero-extended request value.
  assign push_ext  = {{VAL_W{1'b0}}, req_i.push_value};
  assign mem_wdata = push_ext[WORD_BITS-1:0];

  // Requests are taken only in the idle state and while the output
  // register can take the response.
  assign in_ready    = (state_q == dssa_pkg::FSM_IDLE) && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && in_ready;
  assign req_i.ready = in_ready;

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.read_value = out_value_q;
  assign rsp_o.status     = out_status_q;

  // Next state: a successful pop or peek enters the read state to wait for the memory.
  always_comb begin
    state_d = state_q;
    case (state_q)
      dssa_pkg::FSM_IDLE: begin
        if (accept) begin
          if (((req_i.command == dssa_pkg::CMD_POP_LO) ||
               (req_i.command == dssa_pkg::CMD_PEEK_LO)) && !low_empty) begin
            state_d = dssa_pkg::FSM_READ;
          end else if (((req_i.command == dssa_pkg::CMD_POP_HI) ||
                        (req_i.command == dssa_pkg::CMD_PEEK_HI)) && !high_empty) begin
            state_d = dssa_pkg::FSM_READ;
          end
        end
      end
      dssa_pkg::FSM_READ: begin
        state_d = dssa_pkg::FSM_IDLE;
      end
      default: begin
        state_d = dssa_pkg::FSM_IDLE;
      end
    endcase
  end

  // Outputs: memory access, count updates and the response register.
  always_comb begin
    low_d        = low_q;
    high_d       = high_q;
    mem_we       = 1'b0;
    mem_waddr    = lo_push_idx[ADDR_W-1:0];
    mem_re       = 1'b0;
    mem_raddr    = lo_top_idx[ADDR_W-1:0];
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_value_d  = out_value_q;
    out_status_d = out_status_q;

    case (state_q)
      dssa_pkg::FSM_IDLE: begin
        if (accept) begin
          // Default response: zero data with OK status. A successful pop or
          // peek overrides this by loading nothing until the read returns.
          out_valid_d  = 1'b1;
          out_value_d  = '0;
          out_status_d = dssa_pkg::STAT_OK;
          case (req_i.command)
            dssa_pkg::CMD_PUSH_LO: begin
              if (full) begin
                out_status_d = dssa_pkg::STAT_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = lo_push_idx[ADDR_W-1:0];
                low_d     = low_q + CNT_W'(1);
              end
            end
            dssa_pkg::CMD_PUSH_HI: begin
              if (full) begin
                out_status_d = dssa_pkg::STAT_OVERFLOW;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = hi_push_idx[ADDR_W-1:0];
                high_d    = high_q + CNT_W'(1);
              end
            end
            dssa_pkg::CMD_POP_LO, dssa_pkg::CMD_PEEK_LO: begin
              if (low_empty) begin
                out_status_d = dssa_pkg::STAT_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                mem_re      = 1'b1;
                mem_raddr   = lo_top_idx[ADDR_W-1:0];
                if (req_i.command == dssa_pkg::CMD_POP_LO) begin
                  low_d = low_q - CNT_W'(1);
                end
              end
            end
            dssa_pkg::CMD_POP_HI, dssa_pkg::CMD_PEEK_HI: begin
              if (high_empty) begin
                out_status_d = dssa_pkg::STAT_EMPTY;
              end else begin
                out_valid_d = 1'b0;
                mem_re      = 1'b1;
                mem_raddr   = hi_top_idx[ADDR_W-1:0];
                if (req_i.command == dssa_pkg::CMD_POP_HI) begin
                  high_d = high_q - CNT_W'(1);
                end
              end
            end
            default: begin
              // Unused command codes leave the state alone and answer OK.
            end
          endcase
        end
      end
      dssa_pkg::FSM_READ: begin
        // The output register is empty here, since it was free when the
        // request was accepted and nothing was loaded then.
        out_valid_d  = 1'b1;
        out_value_d  = VAL_W'($signed(rd_data_q));
        out_status_d = dssa_pkg::STAT_OK;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dssa_pkg::FSM_IDLE;
      low_q       <= '0;
      high_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_value_q  <= out_value_d;
    out_status_q <= out_status_d;
  end

`ifndef SYNTHESIS
  // The two stacks never hold more words than the memory has entries.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, low_q} + {1'b0, high_q}) <= (CNT_W + 1)'(DEPTH))
    else $error("stack counts exceed memory depth");

  // While a read is outstanding the output register must be free.
  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dssa_pkg::FSM_READ) |-> !out_valid_q)
    else $error("read returned while output register occupied");

  // A push into a full memory answers overflow and leaves the counts alone.
  a_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && full && ((req_i.command == dssa_pkg::CMD_PUSH_LO) ||
                        (req_i.command == dssa_pkg::CMD_PUSH_HI)))
    |=> (out_valid_q && (out_status_q == dssa_pkg::STAT_OVERFLOW) &&
         $stable(low_q) && $stable(high_q)))
    else $error("push into full memory not rejected");

  // A completed read always produces a response in the following cycle.
  a_read_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dssa_pkg::FSM_READ) |=>
      (out_valid_q && (out_status_q == dssa_pkg::STAT_OK)))
    else $error("read did not produce a response");
`endif

endmodule

`default_nettype wire
